### sv/clnw_pkg.sv
// Shared types, constants and encoding functions for the character-LCD nibble writer.
package clnw_pkg;

    localparam int unsigned DIGITS    = 3;
    localparam int unsigned MAX_XFERS = 12;
    localparam int unsigned CNT_W     = $clog2(MAX_XFERS + 1);
    localparam int unsigned FQ_DEPTH  = 4;
    localparam int unsigned FQ_AW     = $clog2(FQ_DEPTH);

    localparam logic [7:0] INS_CLEAR   = 8'h01;
    localparam logic [7:0] INS_LINE2   = 8'hC0;
    localparam logic [7:0] INS_CUR_OFF = 8'h0C;
    localparam logic [7:0] CHR_DOT     = 8'h2E;
    localparam logic [4:0] CELL_BIN    = 5'd21;
    localparam logic [4:0] CELL_DEC    = 5'd20;

    typedef enum logic [2:0] {
        CMD_CHAR    = 3'd0,
        CMD_CELL    = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_INIT    = 3'd3,
        CMD_NEWLINE = 3'd4,
        CMD_CUR_OFF = 3'd5,
        CMD_BINARY  = 3'd6,
        CMD_DECIMAL = 3'd7
    } t_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] char_code;
        logic [4:0] cell_req;
        logic [7:0] number;
    } t_in;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic       last;
    } t_out;

    // one queued bus byte; single sends only the low nibble
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       single;
        logic       last;
    } t_xfer;

    function automatic logic [7:0] cell_code(input logic [4:0] idx);
        return {1'b1, idx[4], 2'b00, idx[3:0]};
    endfunction

    function automatic logic [7:0] map_char(input logic [7:0] c);
        case (c) inside
            [8'h30:8'h3A], 8'h2D, 8'h2E, 8'h20,
            8'h41, 8'h46, 8'h48, 8'h4B, 8'h4D, 8'h50, 8'h53, 8'h54,
            8'h62, 8'h64, 8'h67, 8'h6F, 8'h73, 8'h7A: return c;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [3:0] init_nib(input logic [CNT_W-1:0] idx);
        case (idx)
            CNT_W'(0): return 4'h2;
            CNT_W'(1): return 4'h2;
            CNT_W'(2): return 4'h8;
            CNT_W'(3): return 4'h0;
            CNT_W'(4): return 4'hE;
            CNT_W'(5): return 4'h0;
            CNT_W'(6): return 4'h6;
            default:   return 4'h0;
        endcase
    endfunction

    // binary display: b7 b6 . b5 b4 . b3 b2 . b1 b0
    function automatic logic [7:0] bin_char(input logic [CNT_W-1:0] j, input logic [7:0] num);
        case (j)
            CNT_W'(0):  return {7'b0011000, num[7]};
            CNT_W'(1):  return {7'b0011000, num[6]};
            CNT_W'(3):  return {7'b0011000, num[5]};
            CNT_W'(4):  return {7'b0011000, num[4]};
            CNT_W'(6):  return {7'b0011000, num[3]};
            CNT_W'(7):  return {7'b0011000, num[2]};
            CNT_W'(9):  return {7'b0011000, num[1]};
            CNT_W'(10): return {7'b0011000, num[0]};
            default:    return CHR_DOT;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] xfer_count(input logic [2:0] cmd);
        case (cmd)
            CMD_INIT:    return CNT_W'(7);
            CMD_BINARY:  return CNT_W'(12);
            CMD_DECIMAL: return CNT_W'(DIGITS + 1);
            default:     return CNT_W'(1);
        endcase
    endfunction

endpackage

### sv/clnw_front.sv
// Request front end: latches a request and issues its bus bytes into the queue.
module clnw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  clnw_pkg::t_in       i_item,
    output logic                full,
    output logic                o_q_push,
    output clnw_pkg::t_xfer     o_q_data,
    input  logic                i_q_full
);
    import clnw_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;
    t_in              r_req;
    logic [2:0][3:0]  r_dig;

    logic [6:0]       rem100;
    logic [1:0]       hund;
    logic [3:0]       tens;
    logic [3:0]       units;
    logic [CNT_W-1:0] j;
    logic [CNT_W-1:0] p;
    logic [3:0]       dig;
    t_xfer            xfer;

    // decimal digits by constant compare and subtract
    always_comb begin
        if (i_item.number >= 8'd200) begin
            hund   = 2'd2;
            rem100 = 7'(i_item.number - 8'd200);
        end else if (i_item.number >= 8'd100) begin
            hund   = 2'd1;
            rem100 = 7'(i_item.number - 8'd100);
        end else begin
            hund   = 2'd0;
            rem100 = i_item.number[6:0];
        end
        if      (rem100 >= 7'd90) tens = 4'd9;
        else if (rem100 >= 7'd80) tens = 4'd8;
        else if (rem100 >= 7'd70) tens = 4'd7;
        else if (rem100 >= 7'd60) tens = 4'd6;
        else if (rem100 >= 7'd50) tens = 4'd5;
        else if (rem100 >= 7'd40) tens = 4'd4;
        else if (rem100 >= 7'd30) tens = 4'd3;
        else if (rem100 >= 7'd20) tens = 4'd2;
        else if (rem100 >= 7'd10) tens = 4'd1;
        else                      tens = 4'd0;
        units = 4'(rem100 - 7'(tens) * 7'd10);
    end

    always_comb begin
        j   = r_idx - CNT_W'(1);
        p   = CNT_W'(DIGITS) - r_idx;
        dig = (p < CNT_W'(3)) ? r_dig[p[1:0]] : 4'd0;
        xfer.rs     = 1'b0;
        xfer.data   = 8'h00;
        xfer.single = 1'b0;
        xfer.last   = (r_idx == r_count - CNT_W'(1));
        case (r_req.cmd)
            CMD_CHAR: begin
                xfer.rs   = 1'b1;
                xfer.data = map_char(r_req.char_code);
            end
            CMD_CELL:    xfer.data = cell_code(r_req.cell_req);
            CMD_CLEAR:   xfer.data = INS_CLEAR;
            CMD_INIT: begin
                xfer.data   = {4'h0, init_nib(r_idx)};
                xfer.single = 1'b1;
            end
            CMD_NEWLINE: xfer.data = INS_LINE2;
            CMD_CUR_OFF: xfer.data = INS_CUR_OFF;
            CMD_BINARY: begin
                if (r_idx == '0) begin
                    xfer.data = cell_code(CELL_BIN);
                end else begin
                    xfer.rs   = 1'b1;
                    xfer.data = bin_char(j, r_req.number);
                end
            end
            default: begin
                if (r_idx == '0) begin
                    xfer.data = cell_code(CELL_DEC);
                end else begin
                    xfer.rs   = 1'b1;
                    xfer.data = {4'h3, dig};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (!r_busy) begin
            if (push) begin
                r_busy  <= 1'b1;
                r_idx   <= '0;
                r_req   <= i_item;
                r_count <= xfer_count(i_item.cmd);
                r_dig   <= {{2'b00, hund}, tens, units};
            end
        end else if (!i_q_full) begin
            if (xfer.last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    assign full     = r_busy;
    assign o_q_push = r_busy && !i_q_full;
    assign o_q_data = xfer;

endmodule

### sv/clnw_queue.sv
// Short transfer queue between the front end and the bus back end.
module clnw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clnw_pkg::t_xfer i_data,
    output logic            o_full,
    input  logic            i_pop,
    output clnw_pkg::t_xfer o_data,
    output logic            o_empty
);
    import clnw_pkg::*;

    t_xfer            r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wp;
    logic [FQ_AW-1:0] r_rp;
    logic [FQ_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= r_wp + FQ_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FQ_AW'(1);
            end
            r_cnt <= r_cnt + (FQ_AW+1)'(i_push) - (FQ_AW+1)'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (FQ_AW+1)'(FQ_DEPTH));

endmodule

### sv/clnw_back.sv
// Bus back end: splits queued bytes into nibbles, high first, into the output register.
module clnw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  clnw_pkg::t_xfer i_q_data,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    output logic            empty,
    input  logic            pop,
    output clnw_pkg::t_out  o_item
);
    import clnw_pkg::*;

    logic r_valid;
    logic r_hi_done;
    t_out r_out;
    logic load;
    logic send_low;

    assign load     = (!r_valid || pop) && !i_q_empty;
    assign send_low = i_q_data.single || r_hi_done;
    assign o_q_pop  = load && send_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_hi_done <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_out.reg_select <= i_q_data.rs;
            if (send_low) begin
                r_out.nibble <= i_q_data.data[3:0];
                r_out.last   <= i_q_data.last;
                r_hi_done    <= 1'b0;
            end else begin
                r_out.nibble <= i_q_data.data[7:4];
                r_out.last   <= 1'b0;
                r_hi_done    <= 1'b1;
            end
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

    assign empty  = !r_valid;
    assign o_item = r_out;

endmodule

### sv/char_lcd_nibble_writer_core.sv
// Top level of the character-LCD nibble writer.
// Usage:
//   Requests enter through a queue-style port: an item is taken at a clock
//   edge with push high and full low. Each request yields 2 to 24 bus
//   transfers (register select, nibble, last), high nibble of each byte
//   first (init nibbles are sent alone); last marks the final transfer of a request.
//   Transfers leave through a queue-style port: the oldest one is on o_item
//   while empty is low and is taken at an edge with pop high.
// Timing:
//   The front end issues one byte (or init nibble) per cycle into a 4-entry queue
//   while it is not full; the back end sends one nibble per cycle through its
//   output register while pop is high and the queue is not empty. The first
//   transfer passes through the front end, the queue and the output register.
//   A request holds full high until its queue entries (1, 7, 12 or DIGITS+1)
//   are all issued, queue stalls included; sustained rate is one nibble per cycle.
// Reset (synchronous, i_rst_n low) empties the queue and output register.
// When the receiver stalls, the output register holds, the queue fills and
// full stays high until the front end can finish issuing.
module char_lcd_nibble_writer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  clnw_pkg::t_in  i_item,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output clnw_pkg::t_out o_item
);
    import clnw_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    t_xfer q_in;
    t_xfer q_out;

    clnw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .o_q_push (q_push),
        .o_q_data (q_in),
        .i_q_full (q_full)
    );

    clnw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    clnw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_item    (o_item)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full)) else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty)) else $error("queue read while empty");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full) else $error("front end idle after accept");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full)) else $error("not empty after reset");

endmodule
